@@ src/sha1_message_digest_defines.svh @@
// assertion macros used by the sha-1 digest controller
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SHA1MD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sha1md assertion failed");

// antecedent implies consequent in the next cycle
`define SHA1MD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sha1md assertion failed");

`endif

@@ src/sha1md_pkg.sv @@
// types and constants shared by the sha-1 digest controller and datapath
package sha1md_pkg;

   localparam int ROUNDS = 80;
   localparam int LENGTH_POS = 56;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ROUND = 6'b000010,
      ST_ADD   = 6'b000100,
      ST_PAD   = 6'b001000,
      ST_PAD2  = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   typedef struct packed {
      logic write_byte;
      logic start;
      logic pad;
      logic clear_all;
      logic put_length;
      logic round;
      logic add;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic fill_full;
      logic pad_long;
      logic last_round;
   } dp_status_type;

endpackage

@@ src/sha1_message_digest.sv @@
// sha-1 message digest, one message byte per input word, digest as one result word
// a byte that neither fills a block nor ends the message is only stored, and the block stays ready for more bytes
// each full 64-byte block then runs 80 rounds on one shared round unit, then the hash add
// message end: one or two padding blocks (each a set-up, 80 rounds and the add), then the result
// no new byte is taken while the one-round-per-cycle compressor works, nor while padding or a result is pending
// reset: synchronous, restores the initial hash words, zero length and fill, no result pending
module sha1_message_digest (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // has_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata    // digest_word0, digest_word1, digest_word2, digest_word3, digest_word4
);

   sha1md_pkg::dp_cmd_type    cmd;
   sha1md_pkg::dp_status_type status;

   sha1md_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .has_byte   (req_tuser),
      .last_byte  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   sha1md_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .data_byte (req_tdata),
      .status    (status),
      .digest    (rsp_tdata)
   );

endmodule

@@ src/sha1md_datapath.sv @@
// sha-1 datapath: block buffer and schedule window, hash and working words, length
module sha1md_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sha1md_pkg::dp_cmd_type cmd,
   input  logic [7:0]             data_byte,
   output sha1md_pkg::dp_status_type status,
   output logic [159:0]           digest
);

   logic [31:0]  win_ff [16];
   logic [31:0]  win_in [16];
   logic [31:0]  h_ff [5];
   logic [31:0]  h_in [5];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  len_ff, len_in;
   logic [159:0] digest_ff, digest_in;
   logic [31:0]  f_val, k_val, temp;
   logic [4:0]   lane_shift;

   always_comb begin
      lane_shift = {~fill_ff[1:0], 3'b000};
      win_in = win_ff;
      if (cmd.write_byte) begin
         win_in[fill_ff[5:2]][lane_shift +: 8] = data_byte;
      end
      if (cmd.pad) begin
         for (int i = 0; i < 64; i++) begin
            if (6'(i) > fill_ff) begin
               win_in[i / 4][8 * (3 - (i % 4)) +: 8] = 8'h00;
            end else if (6'(i) == fill_ff) begin
               win_in[i / 4][8 * (3 - (i % 4)) +: 8] = sha1md_pkg::PAD_BYTE;
            end
         end
      end
      if (cmd.clear_all) begin
         for (int i = 0; i < 16; i++) begin
            win_in[i] = 32'h0;
         end
      end
      if (cmd.put_length) begin
         win_in[14] = len_ff[63:32];
         win_in[15] = len_ff[31:0];
      end
      if (cmd.round) begin
         for (int j = 0; j < 15; j++) begin
            win_in[j] = win_ff[j + 1];
         end
         win_in[15] = {win_ff[13][30:0] ^ win_ff[8][30:0] ^ win_ff[2][30:0] ^ win_ff[0][30:0],
                       win_ff[13][31] ^ win_ff[8][31] ^ win_ff[2][31] ^ win_ff[0][31]};
      end
   end

   always_comb begin
      if (cnt_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = sha1md_pkg::K0;
      end else if (cnt_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1md_pkg::K1;
      end else if (cnt_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = sha1md_pkg::K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = sha1md_pkg::K3;
      end
      temp = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + win_ff[0];
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      cnt_in = cnt_ff;
      if (cmd.start) begin
         a_in = h_ff[0];
         b_in = h_ff[1];
         c_in = h_ff[2];
         d_in = h_ff[3];
         e_in = h_ff[4];
         cnt_in = 7'd0;
      end else if (cmd.round) begin
         a_in = temp;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
         cnt_in = cnt_ff + 7'd1;
      end
   end

   always_comb begin
      h_in = h_ff;
      fill_in = fill_ff;
      len_in = len_ff;
      digest_in = digest_ff;
      if (cmd.write_byte) begin
         fill_in = fill_ff + 6'd1;
         len_in = len_ff + 64'd8;
      end
      if (cmd.add) begin
         h_in[0] = h_ff[0] + a_ff;
         h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
      end
      if (cmd.emit) begin
         digest_in = {h_ff[4], h_ff[3], h_ff[2], h_ff[1], h_ff[0]};
         h_in[0] = sha1md_pkg::H0_INIT;
         h_in[1] = sha1md_pkg::H1_INIT;
         h_in[2] = sha1md_pkg::H2_INIT;
         h_in[3] = sha1md_pkg::H3_INIT;
         h_in[4] = sha1md_pkg::H4_INIT;
         fill_in = 6'd0;
         len_in = 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      digest_ff <= digest_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff[0] <= sha1md_pkg::H0_INIT;
         h_ff[1] <= sha1md_pkg::H1_INIT;
         h_ff[2] <= sha1md_pkg::H2_INIT;
         h_ff[3] <= sha1md_pkg::H3_INIT;
         h_ff[4] <= sha1md_pkg::H4_INIT;
         fill_ff <= 6'd0;
         len_ff <= 64'd0;
         cnt_ff <= 7'd0;
      end else begin
         h_ff <= h_in;
         fill_ff <= fill_in;
         len_ff <= len_in;
         cnt_ff <= cnt_in;
      end
   end

   assign status.fill_full = (fill_ff == 6'd63);
   assign status.pad_long = (fill_ff >= 6'(sha1md_pkg::LENGTH_POS));
   assign status.last_round = (cnt_ff == 7'(sha1md_pkg::ROUNDS - 1));
   assign digest = digest_ff;

endmodule

@@ src/sha1md_control.sv @@
// sha-1 controller: byte intake, padding sequence, round sequencing and result handshake
`include "sha1_message_digest_defines.svh"

module sha1md_control (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      has_byte,
   input  logic                      last_byte,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output sha1md_pkg::dp_cmd_type    cmd,
   input  sha1md_pkg::dp_status_type status
);

   sha1md_pkg::state_type state_ff, state_in;
   sha1md_pkg::state_type ret_ff, ret_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic slot_free;

   assign req_tready = (state_ff == sha1md_pkg::ST_IDLE);
   assign accept = req_tvalid & req_tready;
   assign slot_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      cmd = '0;
      case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.write_byte = has_byte;
               if (has_byte && status.fill_full) begin
                  cmd.start = 1'b1;
                  state_in = sha1md_pkg::ST_ROUND;
                  ret_in = last_byte ? sha1md_pkg::ST_PAD : sha1md_pkg::ST_IDLE;
               end else if (last_byte) begin
                  state_in = sha1md_pkg::ST_PAD;
               end
            end
         end
         sha1md_pkg::ST_PAD: begin
            cmd.pad = 1'b1;
            cmd.put_length = ~status.pad_long;
            cmd.start = 1'b1;
            state_in = sha1md_pkg::ST_ROUND;
            ret_in = status.pad_long ? sha1md_pkg::ST_PAD2 : sha1md_pkg::ST_OUT;
         end
         sha1md_pkg::ST_PAD2: begin
            cmd.clear_all = 1'b1;
            cmd.put_length = 1'b1;
            cmd.start = 1'b1;
            state_in = sha1md_pkg::ST_ROUND;
            ret_in = sha1md_pkg::ST_OUT;
         end
         sha1md_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            if (status.last_round) begin
               state_in = sha1md_pkg::ST_ADD;
            end
         end
         sha1md_pkg::ST_ADD: begin
            cmd.add = 1'b1;
            state_in = ret_ff;
         end
         sha1md_pkg::ST_OUT: begin
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = sha1md_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha1md_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1md_pkg::ST_IDLE;
         ret_ff <= sha1md_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `SHA1MD_ASSERT_NEXT(a_full_block_compresses, accept && has_byte && status.fill_full, state_ff == sha1md_pkg::ST_ROUND)
   `SHA1MD_ASSERT_NEXT(a_rounds_continue, state_ff == sha1md_pkg::ST_ROUND && !status.last_round, state_ff == sha1md_pkg::ST_ROUND)
   `SHA1MD_ASSERT_NEXT(a_final_add_to_out, state_ff == sha1md_pkg::ST_ADD && ret_ff == sha1md_pkg::ST_OUT, state_ff == sha1md_pkg::ST_OUT)
   `SHA1MD_ASSERT_SAME(a_ret_never_round, state_ff == sha1md_pkg::ST_ADD, ret_ff != sha1md_pkg::ST_ROUND && ret_ff != sha1md_pkg::ST_ADD)
   `SHA1MD_ASSERT_NEXT(a_emit_shows_word, state_ff == sha1md_pkg::ST_OUT && slot_free, rsp_tvalid && state_ff == sha1md_pkg::ST_IDLE)

endmodule
